[hdl/htb_pkg.sv]
// Shared types, constants and decode helpers for the hex text decoder.
// Used by the channel interfaces and by the top level hex_text_to_bytes.
package htb_pkg;

    // Output byte counter width (valid range 8 to 32)
    localparam int COUNT_WIDTH = 16;
    localparam int CHAR_W      = 8;
    localparam int CFG_W       = 16;
    localparam int STATUS_W    = 3;
    // Width at which the byte count and the capacity are compared
    localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    // Characters with a role of their own
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CHAR_X_LC  = 8'h78;  // 'x'
    localparam logic [CHAR_W-1:0] CHAR_A_LC  = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CHAR_F_LC  = 8'h66;  // 'f'
    localparam logic [CHAR_W-1:0] CHAR_A_UC  = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_F_UC  = 8'h46;  // 'F'
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

    // Offsets that map letter digits onto 10..15
    localparam logic [CHAR_W-1:0] LC_OFFSET  = 8'h57;
    localparam logic [CHAR_W-1:0] UC_OFFSET  = 8'h37;

    // Completion status of one text
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_ODD     = 3'd2,
        ST_TRUNC   = 3'd3,
        ST_CAP     = 3'd4
    } status_t;

    // Return {is_hex, nibble} for one character
    function automatic logic [4:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] diff;
        logic [4:0]        res;
        diff = '0;
        res  = '0;
        if (c inside {[CHAR_ZERO:CHAR_NINE]})
        begin
            diff = c - CHAR_ZERO;
            res  = {1'b1, diff[3:0]};
        end
        else if (c inside {[CHAR_A_LC:CHAR_F_LC]})
        begin
            diff = c - LC_OFFSET;
            res  = {1'b1, diff[3:0]};
        end
        else if (c inside {[CHAR_A_UC:CHAR_F_UC]})
        begin
            diff = c - UC_OFFSET;
            res  = {1'b1, diff[3:0]};
        end
        return res;
    endfunction

    // Space, TAB, LF, VT, FF and CR
    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
    endfunction

endpackage

[hdl/htb_channels.sv]
// Valid/ready channel interfaces of the hex text decoder: character input,
// decoded byte output and capacity register write. Depends on htb_pkg.
interface htb_in_if import htb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              last;

    modport source (output valid, output in_char, output last, input ready);
    modport sink   (input valid, input in_char, input last, output ready);
endinterface

interface htb_out_if import htb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   out_byte;
    logic                byte_valid;
    logic                done_res;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output out_byte, output byte_valid,
                    output done_res, output status, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input done_res, input status, output ready);
endinterface

interface htb_cfg_if import htb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] max_out_bytes;

    modport source (output valid, output max_out_bytes, input ready);
    modport sink   (input valid, input max_out_bytes, output ready);
endinterface

[hdl/hex_text_to_bytes.sv]
// Streaming ASCII-hex to binary decoder, top level.
// Depends on htb_pkg and the channel interfaces in htb_channels.sv.
// A result appears on dout in the cycle after its character beat is taken.
// Throughput: one character per cycle unless dout stalls; the decode and
// nibble merge is one combinational pass from the decoder state into the output register.
// Reset (rst_n low, asynchronous) clears the decoder state, the byte count,
// the output register and sets max_out_bytes to 0 (no limit).
module hex_text_to_bytes
    import htb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    htb_in_if.sink       din,
    htb_cfg_if.sink      cfg,
    htb_out_if.source    dout
);

    typedef struct packed {
        logic                   have_high;
        logic [3:0]             high_nibble;
        status_t                err;
        logic [COUNT_WIDTH-1:0] count;
        logic                   emit;
        logic [CHAR_W-1:0]      data;
    } dec_t;

    // Place one nibble; emit a byte when the pair completes and room is left
    function automatic dec_t take_digit(input dec_t s, input logic [3:0] v,
                                        input logic [CFG_W-1:0] cap);
        dec_t r;
        r = s;
        if (!s.have_high)
        begin
            r.high_nibble = v;
            r.have_high   = 1'b1;
        end
        else
        begin
            r.have_high = 1'b0;
            if ((cap != '0) && (CMP_W'(s.count) >= CMP_W'(cap)))
            begin
                if (s.err == ST_OK)
                    r.err = ST_CAP;
            end
            else
            begin
                r.emit = 1'b1;
                r.data = {s.high_nibble, v};
                if (s.count != '1)
                    r.count = s.count + 1'b1;
            end
        end
        return r;
    endfunction

    // Decoder state
    logic                   zero_pending_reg, zero_pending_next;
    logic [3:0]             high_nibble_reg, high_nibble_next;
    logic                   have_high_reg, have_high_next;
    logic [1:0]             prefix_due_reg, prefix_due_next;
    status_t                error_reg, error_next;
    logic [COUNT_WIDTH-1:0] bytes_done_reg, bytes_done_next;
    logic [CFG_W-1:0]       max_out_bytes_reg;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      out_byte_reg;
    logic                   byte_valid_reg;
    logic                   done_res_reg;
    logic [STATUS_W-1:0]    status_reg;

    logic                   in_fire;
    logic                   has_result;
    logic                   res_emit;
    logic [CHAR_W-1:0]      res_byte;
    logic [STATUS_W-1:0]    res_status;

    // Take a beat whenever the output register is free or being drained
    assign din.ready = !out_valid_reg || dout.ready;
    assign in_fire   = din.valid && din.ready;
    assign cfg.ready = 1'b1;

    // Decode one character
    always_comb
    begin
        dec_t              s;
        logic [4:0]        hn;
        logic              zp;
        logic [1:0]        pdd;
        logic              plain;

        s.have_high   = have_high_reg;
        s.high_nibble = high_nibble_reg;
        s.err         = error_reg;
        s.count       = bytes_done_reg;
        s.emit        = 1'b0;
        s.data        = '0;
        zp            = zero_pending_reg;
        pdd           = prefix_due_reg;
        plain         = 1'b0;
        hn            = hex_nibble(din.in_char);

        if ((error_reg != ST_INVALID) && (error_reg != ST_TRUNC))
        begin
            if (prefix_due_reg != 2'd0)
            begin
                // Digits after a 0x prefix
                if (din.last && (prefix_due_reg == 2'd2))
                    s.err = ST_TRUNC;
                else if (!hn[4])
                    s.err = ST_INVALID;
                else
                begin
                    s   = take_digit(s, hn[3:0], max_out_bytes_reg);
                    pdd = prefix_due_reg - 2'd1;
                    if (din.last && (pdd != 2'd0))
                        s.err = ST_TRUNC;
                end
            end
            else if (zero_pending_reg)
            begin
                // Resolve the held zero: prefix or plain digit
                zp = 1'b0;
                if (din.in_char == CHAR_X_LC)
                begin
                    if (din.last)
                        s.err = ST_TRUNC;
                    else
                        pdd = 2'd2;
                end
                else
                begin
                    s     = take_digit(s, 4'd0, max_out_bytes_reg);
                    plain = 1'b1;
                end
            end
            else
                plain = 1'b1;
        end

        // Ordinary character handling
        if (plain && !is_space(din.in_char))
        begin
            if ((din.in_char == CHAR_ZERO) && !din.last)
                zp = 1'b1;
            else if (!hn[4])
                s.err = ST_INVALID;
            else
                s = take_digit(s, hn[3:0], max_out_bytes_reg);
        end

        // End of text: odd digit check
        if (din.last && ((s.err == ST_OK) || (s.err == ST_CAP)) && s.have_high)
            s.err = ST_ODD;

        has_result = s.emit || din.last;
        res_emit   = s.emit;
        res_byte   = s.emit ? s.data : '0;
        res_status = din.last ? s.err : ST_OK;

        // Return to reset state after the last character
        if (din.last)
        begin
            zero_pending_next = 1'b0;
            high_nibble_next  = '0;
            have_high_next    = 1'b0;
            prefix_due_next   = 2'd0;
            error_next        = ST_OK;
            bytes_done_next   = '0;
        end
        else
        begin
            zero_pending_next = zp;
            high_nibble_next  = s.high_nibble;
            have_high_next    = s.have_high;
            prefix_due_next   = pdd;
            error_next        = s.err;
            bytes_done_next   = s.count;
        end
    end

    // Output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
            out_valid_next = has_result;
        else if (dout.ready)
            out_valid_next = 1'b0;
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_pending_reg  <= 1'b0;
            high_nibble_reg   <= '0;
            have_high_reg     <= 1'b0;
            prefix_due_reg    <= 2'd0;
            error_reg         <= ST_OK;
            bytes_done_reg    <= '0;
            max_out_bytes_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                max_out_bytes_reg <= cfg.max_out_bytes;
            if (in_fire)
            begin
                zero_pending_reg <= zero_pending_next;
                high_nibble_reg  <= high_nibble_next;
                have_high_reg    <= have_high_next;
                prefix_due_reg   <= prefix_due_next;
                error_reg        <= error_next;
                bytes_done_reg   <= bytes_done_next;
            end
        end
    end

    // Load the result beat payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_byte_reg   <= '0;
            byte_valid_reg <= 1'b0;
            done_res_reg   <= 1'b0;
            status_reg     <= ST_OK;
        end
        else if (in_fire && has_result)
        begin
            out_byte_reg   <= res_byte;
            byte_valid_reg <= res_emit;
            done_res_reg   <= din.last;
            status_reg     <= res_status;
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.out_byte   = out_byte_reg;
    assign dout.byte_valid = byte_valid_reg;
    assign dout.done_res   = done_res_reg;
    assign dout.status     = status_reg;

    // A result beat always carries a byte or an end of text
    a_beat_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> (dout.byte_valid || dout.done_res))
        else $error("result beat with neither byte nor done");

    // Status is zero except on the done beat
    a_status_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && !dout.done_res) |-> (dout.status == ST_OK))
        else $error("status set on a non-final beat");

    // Byte field is zero when no byte is carried
    a_byte_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && !dout.byte_valid) |-> (dout.out_byte == '0))
        else $error("byte field not cleared");

    // State returns to reset after the last character
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && din.last) |=> (bytes_done_reg == '0 && !have_high_reg &&
                                   !zero_pending_reg && prefix_due_reg == 2'd0))
        else $error("decoder state not cleared after last");

    // A held zero and due prefix digits never coexist
    a_zero_vs_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (prefix_due_reg != 2'd0) |-> !zero_pending_reg)
        else $error("held zero while prefix digits are due");

endmodule
